@@ design/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants, codes and the sideband type for the plane intersect core.
// ----------------------------------------------------------------------------
package plc_pkg;

    // default fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // coordinate, difference and product widths
    localparam int CW = 32;
    localparam int DW = CW + 1;
    localparam int PW = DW + CW;

    // quotient bits produced by the divider (one above the saturated range)
    localparam int QB = 33;

    // function codes
    localparam logic [1:0] FUNC_LINE = 2'd0;
    localparam logic [1:0] FUNC_SEG  = 2'd1;
    localparam logic [1:0] FUNC_DIST = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_PLANE_X  = 3'd0;
    localparam logic [2:0] REG_PLANE_Y  = 3'd1;
    localparam logic [2:0] REG_PLANE_Z  = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;
    localparam logic [2:0] REG_EPS      = 3'd6;

    // per-item data that rides alongside the divider
    typedef struct packed {
        logic [1:0]          func;
        logic [2:0][CW-1:0]  a;
        logic [2:0][DW-1:0]  d;
        logic [CW-1:0]       dist_val;
        logic                dist_sat;
        logic                parallel;
        logic                neg;
    } plc_side_t;

endpackage

@@ design/plc_dot.sv @@
// ----------------------------------------------------------------------------
// plc_dot
// Difference, product, sum and magnitude stages: numerator, denominator and distance.
// ----------------------------------------------------------------------------
module plc_dot #(
    parameter int FRAC_BITS = plc_pkg::FRAC_BITS_DEF,
    parameter int SW        = plc_pkg::PW - FRAC_BITS + 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [1:0]                     func,
    input  logic [2:0][plc_pkg::CW-1:0]    a,
    input  logic [2:0][plc_pkg::CW-1:0]    b,
    input  logic [2:0][plc_pkg::CW-1:0]    plane,
    input  logic [2:0][plc_pkg::CW-1:0]    normal,
    input  logic [30:0]                    eps,
    output logic                           out_valid,
    output logic [SW-1:0]                  an,
    output logic [SW-1:0]                  ad,
    output plc_pkg::plc_side_t             side
);

    localparam int CW = plc_pkg::CW;
    localparam int DW = plc_pkg::DW;
    localparam int PW = plc_pkg::PW;

    logic                     v0_reg, v1_reg, v2_reg, v3_reg;
    logic [1:0]               func0_reg, func1_reg, func2_reg;
    logic [2:0][CW-1:0]       a0_reg, a1_reg, a2_reg;
    logic [2:0][DW-1:0]       d0_reg, d1_reg, d2_reg, pa0_reg;
    logic [2:0][DW-1:0]       d0_next, pa0_next;
    logic [2:0][PW-1:0]       pn1_reg, pd1_reg, pn1_next, pd1_next;
    logic signed [SW-1:0]     num2_reg, den2_reg, num2_next, den2_next;
    logic [SW-1:0]            an3_reg, ad3_reg, an3_next, ad3_next;
    plc_pkg::plc_side_t       side3_reg, side3_next;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // form plane minus point and the direction
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa0_next[i] = DW'($signed(plane[i])) - DW'($signed(a[i]));
            if (func == plc_pkg::FUNC_SEG)
                d0_next[i] = DW'($signed(b[i])) - DW'($signed(a[i]));
            else
                d0_next[i] = DW'($signed(b[i]));
        end
    end

    // multiply by the normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pn1_next[i] = PW'($signed(pa0_reg[i])) * PW'($signed(normal[i]));
            pd1_next[i] = PW'($signed(d0_reg[i])) * PW'($signed(normal[i]));
        end
    end

    // floor-shift and sum the products
    always_comb
    begin
        num2_next = '0;
        den2_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            num2_next = num2_next + SW'($signed(pn1_reg[i][PW-1:FRAC_BITS]));
            den2_next = den2_next + SW'($signed(pd1_reg[i][PW-1:FRAC_BITS]));
        end
    end

    // take magnitudes, sign, parallel test and distance
    always_comb
    begin
        an3_next = num2_reg[SW-1] ? SW'(-num2_reg) : SW'(num2_reg);
        ad3_next = den2_reg[SW-1] ? SW'(-den2_reg) : SW'(den2_reg);
        side3_next.func     = func2_reg;
        side3_next.a        = a2_reg;
        side3_next.d        = d2_reg;
        side3_next.neg      = num2_reg[SW-1] ^ den2_reg[SW-1];
        side3_next.parallel = (ad3_next == '0) || (ad3_next < SW'(eps));
        side3_next.dist_sat = !((&num2_reg[SW-1:CW-1]) || !(|num2_reg[SW-1:CW-1]));
        if (side3_next.dist_sat)
            side3_next.dist_val = num2_reg[SW-1] ? {1'b1, {(CW-1){1'b0}}}
                                                 : {1'b0, {(CW-1){1'b1}}};
        else
            side3_next.dist_val = num2_reg[CW-1:0];
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func0_reg <= func;
            a0_reg    <= a;
            d0_reg    <= d0_next;
            pa0_reg   <= pa0_next;
            func1_reg <= func0_reg;
            a1_reg    <= a0_reg;
            d1_reg    <= d0_reg;
            pn1_reg   <= pn1_next;
            pd1_reg   <= pd1_next;
            func2_reg <= func1_reg;
            a2_reg    <= a1_reg;
            d2_reg    <= d1_reg;
            num2_reg  <= num2_next;
            den2_reg  <= den2_next;
            an3_reg   <= an3_next;
            ad3_reg   <= ad3_next;
            side3_reg <= side3_next;
        end
    end

    assign out_valid = v3_reg;
    assign an        = an3_reg;
    assign ad        = ad3_reg;
    assign side      = side3_reg;

endmodule

@@ design/plc_div.sv @@
// ----------------------------------------------------------------------------
// plc_div
// Pipelined restoring divider: one quotient bit per stage, with overflow check.
// ----------------------------------------------------------------------------
module plc_div #(
    parameter int FRAC_BITS = plc_pkg::FRAC_BITS_DEF,
    parameter int AW        = plc_pkg::PW - FRAC_BITS + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [AW-1:0]           an,
    input  logic [AW-1:0]           ad,
    input  plc_pkg::plc_side_t      side_in,
    output logic                    out_valid,
    output logic [plc_pkg::QB-1:0]  q,
    output logic                    ovf,
    output plc_pkg::plc_side_t      side_out
);

    localparam int QB = plc_pkg::QB;
    localparam int RW = AW + QB;

    logic               v_reg    [QB+1];
    logic [QB-1:0]      q_reg    [QB+1];
    logic               ovf_reg  [QB+1];
    plc_pkg::plc_side_t side_reg [QB+1];
    logic [RW-1:0]      rem_reg  [QB];
    logic [AW-1:0]      ad_reg   [QB];
    logic [RW-1:0]      rem0_next;

    assign rem0_next = RW'(an) << FRAC_BITS;

    // load the scaled dividend and flag a quotient that cannot fit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem0_next;
            ad_reg[0]   <= ad;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= rem0_next >= (RW'(ad) << QB);
            side_reg[0] <= side_in;
        end
    end

    // one trial subtraction per stage, high quotient bit first
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int SH = QB - 1 - k;
        logic [RW-1:0] trial;
        logic          take;

        assign trial = RW'(ad_reg[k]) << SH;
        assign take  = rem_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]    <= {q_reg[k][QB-2:0], take};
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < QB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? rem_reg[k] - trial : rem_reg[k];
                    ad_reg[k+1]  <= ad_reg[k];
                end
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign q         = q_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

@@ design/plc_hit.sv @@
// ----------------------------------------------------------------------------
// plc_hit
// Quotient clamp, segment test, hit point products and the output register.
// ----------------------------------------------------------------------------
module plc_hit #(
    parameter int FRAC_BITS = plc_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [plc_pkg::QB-1:0]  q,
    input  logic                    ovf,
    input  plc_pkg::plc_side_t      side,
    output logic                    out_valid,
    output logic                    hit,
    output logic [plc_pkg::CW-1:0]  hit_x,
    output logic [plc_pkg::CW-1:0]  hit_y,
    output logic [plc_pkg::CW-1:0]  hit_z,
    output logic [plc_pkg::CW-1:0]  line_param,
    output logic [plc_pkg::CW-1:0]  signed_distance,
    output logic                    saturated
);

    localparam int CW = plc_pkg::CW;
    localparam int QB = plc_pkg::QB;
    localparam int PW = plc_pkg::PW;
    localparam int HW = PW - FRAC_BITS + 1;
    localparam logic [QB-1:0] LIM_POS = {2'b00, {(QB-2){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {2'b01, {(QB-2){1'b0}}};
    localparam logic [CW-1:0] ONE     = CW'(1) << FRAC_BITS;

    logic                     v0_reg, v1_reg, v2_reg;
    plc_pkg::plc_side_t       side0_reg, side1_reg;
    logic [CW-1:0]            u0_reg, u1_reg, u0_next;
    logic                     usat0_reg, usat1_reg, usat0_next;
    logic                     miss0_reg, miss1_reg, miss0_next;
    logic [2:0][PW-1:0]       prod1_reg, prod1_next;
    logic [QB-1:0]            lim, qs;
    logic [2:0][HW-1:0]       sum;
    logic [2:0][CW-1:0]       hs;
    logic [2:0]               hsat;

    logic                     hit_reg, sat_reg;
    logic [2:0][CW-1:0]       h_reg;
    logic [CW-1:0]            u_reg, dist_reg;
    logic                     hit_next, sat_next;
    logic [2:0][CW-1:0]       h_next;
    logic [CW-1:0]            u_next, dist_next;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // clamp and sign the quotient, test the segment range
    always_comb
    begin
        lim        = side.neg ? LIM_NEG : LIM_POS;
        usat0_next = ovf || (q > lim);
        qs         = usat0_next ? lim : q;
        u0_next    = side.neg ? CW'(-qs) : qs[CW-1:0];
        miss0_next = side.parallel || (side.func == plc_pkg::FUNC_NONE)
                  || ((side.func == plc_pkg::FUNC_SEG)
                      && (u0_next[CW-1] || ($signed(u0_next) > $signed(ONE))));
    end

    // multiply u by the direction
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod1_next[i] = PW'($signed(u0_reg)) * PW'($signed(side0_reg.d[i]));
    end

    // floor-shift, add the origin and saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i]  = HW'($signed(prod1_reg[i][PW-1:FRAC_BITS]))
                    + HW'($signed(side1_reg.a[i]));
            hsat[i] = !((&sum[i][HW-1:CW-1]) || !(|sum[i][HW-1:CW-1]));
            if (hsat[i])
                hs[i] = sum[i][HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            else
                hs[i] = sum[i][CW-1:0];
        end
    end

    // format the result by function
    always_comb
    begin
        hit_next  = 1'b0;
        sat_next  = 1'b0;
        h_next    = '0;
        u_next    = '0;
        dist_next = '0;
        priority if (side1_reg.func == plc_pkg::FUNC_DIST)
        begin
            hit_next  = 1'b1;
            dist_next = side1_reg.dist_val;
            sat_next  = side1_reg.dist_sat;
        end
        else if (!miss1_reg)
        begin
            hit_next = 1'b1;
            h_next   = hs;
            u_next   = u1_reg;
            sat_next = usat1_reg || (|hsat);
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side0_reg <= side;
            u0_reg    <= u0_next;
            usat0_reg <= usat0_next;
            miss0_reg <= miss0_next;
            side1_reg <= side0_reg;
            u1_reg    <= u0_reg;
            usat1_reg <= usat0_reg;
            miss1_reg <= miss0_reg;
            prod1_reg <= prod1_next;
            hit_reg   <= hit_next;
            sat_reg   <= sat_next;
            h_reg     <= h_next;
            u_reg     <= u_next;
            dist_reg  <= dist_next;
        end
    end

    assign out_valid       = v2_reg;
    assign hit             = hit_reg;
    assign hit_x           = h_reg[0];
    assign hit_y           = h_reg[1];
    assign hit_z           = h_reg[2];
    assign line_param      = u_reg;
    assign signed_distance = dist_reg;
    assign saturated       = sat_reg;

endmodule

@@ design/plane_line_intersect_core.sv @@
// ----------------------------------------------------------------------------
// plane_line_intersect_core
// Line, segment or point against a plane in signed fixed point.
// ----------------------------------------------------------------------------
// The core takes one item every clock cycle unless stalled. Items pass through
// the differences, normal products, sums and magnitudes, then the
// restoring divider (an overflow check and one quotient bit per stage), and
// then the clamp, hit point products and output register. Every stage
// moves together; while a finished result waits under out_stall the whole
// pipeline holds and in_stall is raised. The user must write plane registers
// through the config port while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module plane_line_intersect_core #(
    parameter int FRAC_BITS = plc_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             func,
    input  logic [31:0]            a_x,
    input  logic [31:0]            a_y,
    input  logic [31:0]            a_z,
    input  logic [31:0]            b_x,
    input  logic [31:0]            b_y,
    input  logic [31:0]            b_z,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic [31:0]            hit_x,
    output logic [31:0]            hit_y,
    output logic [31:0]            hit_z,
    output logic [31:0]            line_param,
    output logic [31:0]            signed_distance,
    output logic                   saturated
);

    localparam int CW = plc_pkg::CW;
    localparam int QB = plc_pkg::QB;
    localparam int SW = plc_pkg::PW - FRAC_BITS + 2;

    logic [2:0][CW-1:0]   plane_reg, normal_reg;
    logic [30:0]          eps_reg;
    logic                 en;
    logic                 dot_valid, div_valid;
    logic [SW-1:0]        an, ad;
    plc_pkg::plc_side_t   dot_side, div_side;
    logic [QB-1:0]        q;
    logic                 ovf;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg  <= '0;
            normal_reg <= {CW'(0), CW'(0), CW'(1) << FRAC_BITS};
            eps_reg    <= 31'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                plc_pkg::REG_PLANE_X:  plane_reg[0]  <= cfg_data;
                plc_pkg::REG_PLANE_Y:  plane_reg[1]  <= cfg_data;
                plc_pkg::REG_PLANE_Z:  plane_reg[2]  <= cfg_data;
                plc_pkg::REG_NORMAL_X: normal_reg[0] <= cfg_data;
                plc_pkg::REG_NORMAL_Y: normal_reg[1] <= cfg_data;
                plc_pkg::REG_NORMAL_Z: normal_reg[2] <= cfg_data;
                plc_pkg::REG_EPS:      eps_reg       <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // freeze every stage while a result waits
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    plc_dot #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .func      (func),
        .a         ({a_z, a_y, a_x}),
        .b         ({b_z, b_y, b_x}),
        .plane     (plane_reg),
        .normal    (normal_reg),
        .eps       (eps_reg),
        .out_valid (dot_valid),
        .an        (an),
        .ad        (ad),
        .side      (dot_side)
    );

    plc_div #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .an        (an),
        .ad        (ad),
        .side_in   (dot_side),
        .out_valid (div_valid),
        .q         (q),
        .ovf       (ovf),
        .side_out  (div_side)
    );

    plc_hit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hit (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (div_valid),
        .q               (q),
        .ovf             (ovf),
        .side            (div_side),
        .out_valid       (out_valid),
        .hit             (hit),
        .hit_x           (hit_x),
        .hit_y           (hit_y),
        .hit_z           (hit_z),
        .line_param      (line_param),
        .signed_distance (signed_distance),
        .saturated       (saturated)
    );

endmodule

@@ design/plc_checker.sv @@
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks on the plane intersect core, bound to the top level.
// ----------------------------------------------------------------------------
module plc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        hit,
    input  logic [31:0] hit_x,
    input  logic [31:0] hit_y,
    input  logic [31:0] hit_z,
    input  logic [31:0] line_param,
    input  logic [31:0] signed_distance,
    input  logic        saturated
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_x) && $stable(line_param))
        else $error("stalled result changed");

    // stall input only while the output is blocked
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without an output stall");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_x == 32'd0 && hit_y == 32'd0 && hit_z == 32'd0
            && line_param == 32'd0 && signed_distance == 32'd0 && !saturated)
        else $error("miss with nonzero fields");

    // distance and intersection fields never mix
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && signed_distance != 32'd0 |-> line_param == 32'd0 && hit_x == 32'd0)
        else $error("distance and intersection fields both set");

endmodule

bind plane_line_intersect_core plc_checker u_plc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .hit_x           (hit_x),
    .hit_y           (hit_y),
    .hit_z           (hit_z),
    .line_param      (line_param),
    .signed_distance (signed_distance),
    .saturated       (saturated)
);

@@ bench/plane_line_intersect_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane_line_intersect_core_tb
// Drives lines, segments, distance and null queries against a programmable plane and
// checks every result against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------

class plane_hit_board;
    typedef struct {
        logic        hit;
        logic [31:0] hx, hy, hz, u, dist_val;
        logic        sat;
    } plane_hit_t;

    // plane state mirrored from the config writes
    longint px, py, pz, nx, ny, nz;
    longint eps;
    plane_hit_t pending[$];
    int errors;
    int checked;

    function new();
        px = 0; py = 0; pz = 0;
        nx = 64'sd65536; ny = 0; nz = 0;
        eps = 1;
        errors = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        longint sv;
        sv = longint'($signed(v));
        case (idx)
            plc_pkg::REG_PLANE_X:  px = sv;
            plc_pkg::REG_PLANE_Y:  py = sv;
            plc_pkg::REG_PLANE_Z:  pz = sv;
            plc_pkg::REG_NORMAL_X: nx = sv;
            plc_pkg::REG_NORMAL_Y: ny = sv;
            plc_pkg::REG_NORMAL_Z: nz = sv;
            plc_pkg::REG_EPS:      eps = longint'({1'b0, v[30:0]});
            default: ;
        endcase
    endfunction

    // floor division by 2^16 (arithmetic shift floors)
    function longint fl16(longint x);
        return x >>> 16;
    endfunction

    function longint clip32(longint x, inout bit s);
        if (x > 64'sd2147483647) begin s = 1; return 64'sd2147483647; end
        if (x < -64'sd2147483648) begin s = 1; return -64'sd2147483648; end
        return x;
    endfunction

    function longint quotient_q16(longint n, longint d, inout bit s);
        bit neg;
        longint unsigned an, ad, lim, q0, r, q;
        neg = (n < 0) != (d < 0);
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q0 = an / ad;
        r = an % ad;
        if (q0 > 64'h8000) begin
            s = 1;
            q = lim;
        end
        else begin
            q = q0;
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= ad) begin r = r - ad; q = q | 1; end
            end
            if (q > lim) begin s = 1; q = lim; end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_query(logic [1:0] f, logic [31:0] ax, ay, az, bx, by, bz);
        plane_hit_t e;
        longint a[3], d[3], nv[3], p[3];
        longint num, den, u, h;
        bit s;
        e = '{hit: 0, hx: 0, hy: 0, hz: 0, u: 0, dist_val: 0, sat: 0};
        s = 0;
        a[0] = $signed(ax); a[1] = $signed(ay); a[2] = $signed(az);
        d[0] = $signed(bx); d[1] = $signed(by); d[2] = $signed(bz);
        nv[0] = nx; nv[1] = ny; nv[2] = nz;
        p[0] = px; p[1] = py; p[2] = pz;
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++) begin
            if (f == plc_pkg::FUNC_SEG) d[i] = d[i] - a[i];
            num += fl16((p[i] - a[i]) * nv[i]);
            den += fl16(d[i] * nv[i]);
        end
        if (f == plc_pkg::FUNC_DIST) begin
            e.hit = 1;
            e.dist_val = 32'(clip32(num, s));
            e.sat = s;
        end
        else if (f != plc_pkg::FUNC_NONE && den != 0 && (den < 0 ? -den : den) >= eps) begin
            u = quotient_q16(num, den, s);
            if (!(f == plc_pkg::FUNC_SEG && (u < 0 || u > 64'sd65536))) begin
                e.hit = 1;
                h = clip32(fl16(u * d[0]) + a[0], s); e.hx = 32'(h);
                h = clip32(fl16(u * d[1]) + a[1], s); e.hy = 32'(h);
                h = clip32(fl16(u * d[2]) + a[2], s); e.hz = 32'(h);
                e.u = 32'(u);
                e.sat = s;
            end
        end
        pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %h want %h", checked, what, got, want);
    endtask

    task check_result(logic h, logic [31:0] hx, hy, hz, u, dv, logic s);
        plane_hit_t e;
        if (pending.size() == 0) begin
            report("unexpected result", 32'd0, 32'd0);
            return;
        end
        e = pending.pop_front();
        if (h !== e.hit) report("hit", 32'(h), 32'(e.hit));
        if (hx !== e.hx) report("hit_x", hx, e.hx);
        if (hy !== e.hy) report("hit_y", hy, e.hy);
        if (hz !== e.hz) report("hit_z", hz, e.hz);
        if (u !== e.u) report("line_param", u, e.u);
        if (dv !== e.dist_val) report("signed_distance", dv, e.dist_val);
        if (s !== e.sat) report("saturated", 32'(s), 32'(e.sat));
        checked++;
    endtask
endclass

module plane_line_intersect_core_tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic [31:0] hit_x, hit_y, hit_z, line_param, signed_distance;
    logic        saturated;

    plane_hit_board board;
    int          sent;
    int          hold_off;
    bit          sending_done;

    plane_line_intersect_core dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("plane_line_intersect_core verification failed");
        $finish;
    end

    // config write, only while idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        board.set_reg(idx, v);
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    // transfer one query, with a random gap first except in the first 40 of every 200
    task automatic send_query(logic [1:0] f, logic [31:0] ax, ay, az, bx, by, bz);
        int gap;
        gap = (sent % 200 < 40) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        func <= f;
        a_x <= ax; a_y <= ay; a_z <= az;
        b_x <= bx; b_y <= by; b_z <= bz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_query(f, ax, ay, az, bx, by, bz);
        sent++;
        @(negedge clk);
    endtask

    // drop valid and wait for the pipeline to drain
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (board.pending.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic logic [1:0] rand_func();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return plc_pkg::FUNC_NONE;
        if (r < 8) return plc_pkg::FUNC_LINE;
        if (r < 15) return plc_pkg::FUNC_SEG;
        return plc_pkg::FUNC_DIST;
    endfunction

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int w;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0) begin
                out_stall <= 1;
                hold_off--;
            end
            else begin
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
                out_stall <= (w != 0);
                repeat (w > 0 ? w - 1 : 0) @(negedge clk);
            end
        end
    end

    // sample accepted results
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(hit, hit_x, hit_y, hit_z, line_param, signed_distance,
                               saturated);
    end

    initial
    begin
        logic [31:0] pt;
        board = new();
        sent = 0;
        hold_off = 0;
        rst_n = 0;
        cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
        in_valid = 0; func = plc_pkg::FUNC_LINE;
        a_x = 0; a_y = 0; a_z = 0; b_x = 0; b_y = 0; b_z = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed items on the reset plane x = 0
        send_query(plc_pkg::FUNC_LINE, 32'hFFFE_0000, 0, 0, 32'h0001_0000, 0, 0);
        send_query(plc_pkg::FUNC_LINE, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
        send_query(plc_pkg::FUNC_SEG, 32'hFFFF_0000, 5, 7, 32'h0001_0000, 9, 3);
        send_query(plc_pkg::FUNC_SEG, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0);
        send_query(plc_pkg::FUNC_SEG, 0, 0, 0, 32'h0001_0000, 0, 0);
        send_query(plc_pkg::FUNC_DIST, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0);
        send_query(plc_pkg::FUNC_DIST, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   0, 0, 0);
        send_query(plc_pkg::FUNC_NONE, 32'h1234_5678, 1, 2, 3, 4, 5);
        send_query(plc_pkg::FUNC_LINE, 32'h8000_0000, 0, 0, 1, 0, 0);
        send_query(plc_pkg::FUNC_LINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_query(plc_pkg::FUNC_SEG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_query(plc_pkg::FUNC_LINE, 32'h0001_0000, 2, 3, 32'hFFFF_FFFF, 0, 0);
        drain();

        // extreme plane, large eps: parallel rejection
        write_reg(plc_pkg::REG_PLANE_X, 32'h7FFF_FFFF);
        write_reg(plc_pkg::REG_PLANE_Y, 32'h8000_0000);
        write_reg(plc_pkg::REG_PLANE_Z, 32'h0001_0000);
        write_reg(plc_pkg::REG_NORMAL_X, 32'h8000_0000);
        write_reg(plc_pkg::REG_NORMAL_Y, 32'h7FFF_FFFF);
        write_reg(plc_pkg::REG_NORMAL_Z, 32'h0000_8000);
        write_reg(plc_pkg::REG_EPS, 32'h7FFF_FFFF);
        send_query(plc_pkg::FUNC_LINE, 1, 2, 3, 32'h0001_0000, 0, 0);
        send_query(plc_pkg::FUNC_DIST, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_query(plc_pkg::FUNC_LINE, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        drain();

        // random phases, each with a fresh plane
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(plc_pkg::REG_PLANE_X, rand_coord());
            write_reg(plc_pkg::REG_PLANE_Y, rand_coord());
            write_reg(plc_pkg::REG_PLANE_Z, rand_coord());
            write_reg(plc_pkg::REG_NORMAL_X, (ph == 6) ? 32'h0 : rand_coord());
            write_reg(plc_pkg::REG_NORMAL_Y, rand_coord());
            write_reg(plc_pkg::REG_NORMAL_Z, rand_coord());
            write_reg(plc_pkg::REG_EPS, (ph == 0) ? 32'h0 : (ph == 1) ? 32'h7FFF_FFFF :
                                        $urandom_range(0, 32'h100));
            if (ph == 2)
                hold_off = 300;
            for (int k = 0; k < 200; k++)
            begin
                pt = rand_coord();
                if ($urandom_range(0, 3) == 0)
                    send_query(rand_func(), pt, pt, pt, rand_coord(), rand_coord(),
                               rand_coord());
                else
                    send_query(rand_func(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        $display("Sent %0d queries over 9 plane settings; %0d results checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("plane_line_intersect_core verification clean");
        else
            $display("plane_line_intersect_core verification failed");
        $finish;
    end
endmodule
